// File: sv/pair_pool_allocator_defines.svh
// Assertion macros shared by the pair pool allocator RTL.
// Depends on nothing; included by ppa_engine, the module that carries assertions.
`ifndef PAIR_POOL_ALLOCATOR_DEFINES_SVH
`define PAIR_POOL_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PPA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("pair pool allocator: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("pair pool allocator: next-cycle check failed");

`endif

// File: sv/ppa_pkg.sv
// Types, constants and helper functions of the pair pool allocator.
// Depends on nothing; used by every module of the block but ppa_ram.
package ppa_pkg;

	localparam int PAIRS   = 1024;
	localparam int ADDR_W  = $clog2(PAIRS);
	localparam int CELL_W  = 11;
	localparam int VALUE_W = 64;
	localparam int KIND_W  = 3;

	localparam logic [CELL_W-1:0] NULL_CELL = CELL_W'(PAIRS);
	localparam logic [CELL_W-1:0] POOL_RESET = CELL_W'(1024);

	typedef enum logic [KIND_W-1:0] {
		K_ALLOC     = 3'd0,
		K_READ      = 3'd1,
		K_SET_VALUE = 3'd2,
		K_SET_LINK  = 3'd3,
		K_FREE      = 3'd4
	} kind_t;

	typedef struct packed {
		logic [KIND_W-1:0]         kind;
		logic [CELL_W-1:0]         cell_req;
		logic signed [VALUE_W-1:0] value;
		logic [CELL_W-1:0]         next_cell;
	} req_t;

	typedef struct packed {
		logic                      ok;
		logic [CELL_W-1:0]         result_cell;
		logic signed [VALUE_W-1:0] car_value;
		logic [CELL_W-1:0]         cdr_cell;
	} rsp_t;

	// Requests from the engine to the two cell memories.
	typedef struct packed {
		logic               rd_en;
		logic [ADDR_W-1:0]  rd_addr;
		logic               value_we;
		logic               link_we;
		logic [ADDR_W-1:0]  wr_addr;
		logic [VALUE_W-1:0] value_wdata;
		logic [CELL_W-1:0]  link_wdata;
	} mem_req_t;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [CELL_W-1:0]  link;
	} mem_rd_t;

	function automatic logic [CELL_W-1:0] pool_limit(input logic [CELL_W-1:0] pairs);
		return (pairs < NULL_CELL) ? pairs : NULL_CELL;
	endfunction

	// Any index at or above the limit collapses to null.
	function automatic logic [CELL_W-1:0] clean_index(input logic [CELL_W-1:0] raw,
			input logic [CELL_W-1:0] limit);
		return (raw < limit) ? raw : NULL_CELL;
	endfunction

endpackage

// File: sv/ppa_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing; holds the value and link words of the pool.
module ppa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: sv/ppa_engine.sv
// Control of the pair pool: free list head, high-water mark, free count and
// the read-modify-write sequence on the cell memories. Depends on ppa_pkg.
`include "pair_pool_allocator_defines.svh"

module ppa_engine (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [ppa_pkg::CELL_W-1:0]       cfg_data,
	input  logic                             req_valid,
	output logic                             req_ready,
	input  ppa_pkg::req_t                    req,
	output logic                             res_valid,
	input  logic                             res_ready,
	output ppa_pkg::rsp_t                    res,
	output ppa_pkg::mem_req_t                mem,
	input  ppa_pkg::mem_rd_t                 mem_rd
);

	typedef enum logic {S_IDLE, S_EXEC} state_t;

	state_t                        state_q;
	logic [ppa_pkg::CELL_W-1:0]    pool_pairs_q;
	logic [ppa_pkg::CELL_W-1:0]    free_head_q;
	logic [ppa_pkg::CELL_W-1:0]    high_water_q;
	logic [ppa_pkg::CELL_W-1:0]    free_count_q;

	logic [ppa_pkg::KIND_W-1:0]    kind_s1;
	logic [ppa_pkg::CELL_W-1:0]    cell_s1;
	logic [ppa_pkg::VALUE_W-1:0]   value_s1;
	logic [ppa_pkg::CELL_W-1:0]    link_s1;

	logic [ppa_pkg::CELL_W-1:0]    limit;
	logic [ppa_pkg::CELL_W-1:0]    cell_in;
	logic                          accept;
	logic                          finish;
	logic                          head_ok;
	logic                          hw_ok;
	logic                          cell_ok;
	logic                          alloc_ok;
	logic [ppa_pkg::CELL_W-1:0]    got;

	assign limit     = ppa_pkg::pool_limit(pool_pairs_q);
	assign cell_in   = ppa_pkg::clean_index(req.cell_req, limit);
	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;
	assign res_valid = (state_q == S_EXEC);
	assign finish    = res_valid && res_ready;

	assign head_ok  = free_head_q < limit;
	assign hw_ok    = high_water_q < limit;
	assign cell_ok  = cell_s1 != ppa_pkg::NULL_CELL;
	assign alloc_ok = head_ok || hw_ok;
	assign got      = head_ok ? free_head_q : high_water_q;

	// The read is issued as the item is taken: an allocate needs the link of
	// the current free head, every other kind reads its target cell.
	always_comb begin
		mem.rd_en   = accept;
		mem.rd_addr = (req.kind == ppa_pkg::K_ALLOC) ? free_head_q[ppa_pkg::ADDR_W-1:0]
			: cell_in[ppa_pkg::ADDR_W-1:0];
		mem.value_we    = 1'b0;
		mem.link_we     = 1'b0;
		mem.wr_addr     = cell_s1[ppa_pkg::ADDR_W-1:0];
		mem.value_wdata = value_s1;
		mem.link_wdata  = link_s1;

		res.ok          = 1'b1;
		res.result_cell = ppa_pkg::NULL_CELL;
		res.car_value   = '0;
		res.cdr_cell    = ppa_pkg::NULL_CELL;

		case (kind_s1)
			ppa_pkg::K_ALLOC: begin
				mem.wr_addr  = got[ppa_pkg::ADDR_W-1:0];
				mem.value_we = finish && alloc_ok;
				mem.link_we  = finish && alloc_ok;
				res.ok       = alloc_ok;
				if (alloc_ok) begin
					res.result_cell = got;
				end
			end
			ppa_pkg::K_READ: begin
				if (cell_ok) begin
					res.result_cell = cell_s1;
					res.car_value   = mem_rd.value;
					res.cdr_cell    = mem_rd.link;
				end
			end
			ppa_pkg::K_SET_VALUE: begin
				mem.value_we    = finish && cell_ok;
				res.result_cell = cell_s1;
			end
			ppa_pkg::K_SET_LINK: begin
				mem.link_we     = finish && cell_ok;
				res.result_cell = cell_s1;
			end
			ppa_pkg::K_FREE: begin
				mem.link_we     = finish && cell_ok;
				mem.link_wdata  = head_ok ? free_head_q : ppa_pkg::NULL_CELL;
				res.result_cell = cell_s1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			pool_pairs_q <= ppa_pkg::POOL_RESET;
			free_head_q  <= ppa_pkg::NULL_CELL;
			high_water_q <= '0;
			free_count_q <= ppa_pkg::pool_limit(ppa_pkg::POOL_RESET);
		end else begin
			if (cfg_we) begin
				pool_pairs_q <= cfg_data;
				free_head_q  <= ppa_pkg::NULL_CELL;
				high_water_q <= '0;
				free_count_q <= ppa_pkg::pool_limit(cfg_data);
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (finish) begin
						state_q <= S_IDLE;
						if (kind_s1 == ppa_pkg::K_ALLOC && alloc_ok) begin
							if (head_ok) begin
								free_head_q <= ppa_pkg::clean_index(mem_rd.link, limit);
							end else begin
								high_water_q <= ppa_pkg::CELL_W'(high_water_q + 1'b1);
							end
							if (free_count_q != '0) begin
								free_count_q <= ppa_pkg::CELL_W'(free_count_q - 1'b1);
							end
						end
						if (kind_s1 == ppa_pkg::K_FREE && cell_ok) begin
							free_head_q <= cell_s1;
							if (free_count_q < limit) begin
								free_count_q <= ppa_pkg::CELL_W'(free_count_q + 1'b1);
							end
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1  <= req.kind;
			cell_s1  <= cell_in;
			value_s1 <= req.value;
			link_s1  <= ppa_pkg::clean_index(req.next_cell, limit);
		end
	end

	`PPA_ASSERT_NOW(a_hw_bound, clk, arst_n, 1'b1, high_water_q <= limit)
	`PPA_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, free_count_q <= limit)
	`PPA_ASSERT_NOW(a_write_in_exec, clk, arst_n, mem.value_we || mem.link_we,
		finish)
	`PPA_ASSERT_NEXT(a_stall_holds, clk, arst_n, res_valid && !res_ready,
		res_valid && $stable(kind_s1) && $stable(cell_s1))

endmodule

// File: sv/pair_pool_allocator.sv
// Top level of the pair pool allocator: engine, value and link memories,
// and the result register. Depends on ppa_pkg, ppa_engine and ppa_ram.
//
//   channel   direction  handshake              payload
//   req       in         req_valid / req_ready  req   (ppa_pkg::req_t)
//   rsp       out        rsp_valid / rsp_ready  rsp   (ppa_pkg::rsp_t)
//   cfg       in         cfg_we                 cfg_data (pool_pairs)
//
// Each item is read from the cell memories as it is taken (the free head's link
// for an allocate, the target cell otherwise), then updates the memories and loads
// the result register in the execute state; the next item waits until that is done.
// The result register holds one finished item; if it is still full when the
// next item finishes, that item waits in the execute state until it drains.
// Reset takes effect at once, with no clearing pass; cells are valid once written.
module pair_pool_allocator (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [ppa_pkg::CELL_W-1:0] cfg_data,
	input  logic                       req_valid,
	output logic                       req_ready,
	input  ppa_pkg::req_t              req,
	output logic                       rsp_valid,
	input  logic                       rsp_ready,
	output ppa_pkg::rsp_t              rsp
);

	ppa_pkg::mem_req_t mem;
	ppa_pkg::mem_rd_t  mem_rd;
	ppa_pkg::rsp_t     res;
	logic              res_valid;
	logic              res_ready;
	logic              rsp_valid_q;
	ppa_pkg::rsp_t     rsp_q;

	assign res_ready = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	ppa_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.mem       (mem),
		.mem_rd    (mem_rd)
	);

	ppa_ram #(
		.WIDTH (ppa_pkg::VALUE_W),
		.DEPTH (ppa_pkg::PAIRS)
	) u_value_ram (
		.clk   (clk),
		.we    (mem.value_we),
		.waddr (mem.wr_addr),
		.wdata (mem.value_wdata),
		.re    (mem.rd_en),
		.raddr (mem.rd_addr),
		.rdata (mem_rd.value)
	);

	ppa_ram #(
		.WIDTH (ppa_pkg::CELL_W),
		.DEPTH (ppa_pkg::PAIRS)
	) u_link_ram (
		.clk   (clk),
		.we    (mem.link_we),
		.waddr (mem.wr_addr),
		.wdata (mem.link_wdata),
		.re    (mem.rd_en),
		.raddr (mem.rd_addr),
		.rdata (mem_rd.link)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			rsp_q <= res;
		end
	end

endmodule

// File: bench/pool_checker.sv
`timescale 1ns / 100ps
// Response checker for the pair pool allocator: predicts every response from the
// accepted requests and compares it field by field. Depends on ppa_pkg.
module pool_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [ppa_pkg::CELL_W-1:0] cfg_data,
	input  logic                       req_valid,
	input  logic                       req_ready,
	input  ppa_pkg::req_t              req,
	input  logic                       rsp_valid,
	input  logic                       rsp_ready,
	input  ppa_pkg::rsp_t              rsp,
	output int                         mismatches,
	output int                         outstanding,
	output logic [ppa_pkg::CELL_W-1:0] fresh_mark
);

	logic [ppa_pkg::VALUE_W-1:0] value_mem [ppa_pkg::PAIRS];
	logic [ppa_pkg::CELL_W-1:0]  link_mem [ppa_pkg::PAIRS];
	logic [ppa_pkg::CELL_W-1:0]  pool_size;
	logic [ppa_pkg::CELL_W-1:0]  free_top;
	ppa_pkg::rsp_t               answer_q [$];

	function automatic int cell_limit();
		return (pool_size > ppa_pkg::PAIRS) ? ppa_pkg::PAIRS : int'(pool_size);
	endfunction

	function automatic logic [ppa_pkg::CELL_W-1:0] in_pool_or_null(
			input logic [ppa_pkg::CELL_W-1:0] raw, input int lim);
		return (raw < lim) ? raw : ppa_pkg::NULL_CELL;
	endfunction

	// Applies one request to the shadow pool and returns the response it must give.
	task automatic serve(input ppa_pkg::req_t r, output ppa_pkg::rsp_t o);
		int                         lim;
		logic [ppa_pkg::CELL_W-1:0] target;
		logic [ppa_pkg::CELL_W-1:0] link;
		logic [ppa_pkg::CELL_W-1:0] got;
		bit                         have;
		lim = cell_limit();
		target = in_pool_or_null(r.cell_req, lim);
		link = in_pool_or_null(r.next_cell, lim);
		o.ok = 1'b1;
		o.result_cell = ppa_pkg::NULL_CELL;
		o.car_value = '0;
		o.cdr_cell = ppa_pkg::NULL_CELL;
		case (r.kind)
			ppa_pkg::K_ALLOC: begin
				have = 1'b1;
				got = ppa_pkg::NULL_CELL;
				if (free_top < lim) begin
					got = free_top;
					free_top = in_pool_or_null(link_mem[got], lim);
				end else if (fresh_mark < lim) begin
					got = fresh_mark;
					fresh_mark = fresh_mark + 1'b1;
				end else begin
					have = 1'b0;
				end
				if (have) begin
					value_mem[got] = r.value;
					link_mem[got] = link;
					o.result_cell = got;
				end else begin
					o.ok = 1'b0;
				end
			end
			ppa_pkg::K_READ: begin
				if (target < lim) begin
					o.car_value = value_mem[target];
					o.cdr_cell = link_mem[target];
					o.result_cell = target;
				end
			end
			ppa_pkg::K_SET_VALUE: begin
				if (target < lim) begin
					value_mem[target] = r.value;
					o.result_cell = target;
				end
			end
			ppa_pkg::K_SET_LINK: begin
				if (target < lim) begin
					link_mem[target] = link;
					o.result_cell = target;
				end
			end
			ppa_pkg::K_FREE: begin
				// The freed cell's link word becomes the next entry of the free list.
				if (target < lim) begin
					link_mem[target] = (free_top < lim) ? free_top : ppa_pkg::NULL_CELL;
					free_top = target;
					o.result_cell = target;
				end
			end
			default: begin
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		ppa_pkg::rsp_t want;
		if (!arst_n) begin
			pool_size = ppa_pkg::POOL_RESET;
			free_top = ppa_pkg::NULL_CELL;
			fresh_mark = '0;
			answer_q.delete();
			outstanding = 0;
			mismatches = 0;
		end else begin
			if (cfg_we) begin
				pool_size = cfg_data;
				free_top = ppa_pkg::NULL_CELL;
				fresh_mark = '0;
			end
			if (rsp_valid && rsp_ready) begin
				if (answer_q.size() == 0) begin
					$display("%0t: response item with none expected, got %p", $time, rsp);
					mismatches++;
				end else begin
					want = answer_q.pop_front();
					if (rsp.ok !== want.ok) begin
						$display("%0t: ok expected %0b, got %0b", $time, want.ok, rsp.ok);
						mismatches++;
					end
					if (rsp.result_cell !== want.result_cell) begin
						$display("%0t: result_cell expected %0d, got %0d", $time,
							want.result_cell, rsp.result_cell);
						mismatches++;
					end
					if (rsp.car_value !== want.car_value) begin
						$display("%0t: car_value expected %0d, got %0d", $time,
							want.car_value, rsp.car_value);
						mismatches++;
					end
					if (rsp.cdr_cell !== want.cdr_cell) begin
						$display("%0t: cdr_cell expected %0d, got %0d", $time,
							want.cdr_cell, rsp.cdr_cell);
						mismatches++;
					end
				end
			end
			if (req_valid && req_ready) begin
				serve(req, want);
				answer_q.push_back(want);
			end
			outstanding = answer_q.size();
		end
	end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps
// Top of the pair pool allocator bench: clock, reset, pool size settings and
// request traffic with random idling. Depends on ppa_pkg, pool_checker and the RTL.
module testbench;

	localparam int KIND_TOP = (1 << ppa_pkg::KIND_W) - 1;
	localparam logic [ppa_pkg::VALUE_W-1:0] VALUE_MAX = {1'b0, {(ppa_pkg::VALUE_W-1){1'b1}}};
	localparam logic [ppa_pkg::VALUE_W-1:0] VALUE_MIN = {1'b1, {(ppa_pkg::VALUE_W-1){1'b0}}};
	localparam logic [ppa_pkg::VALUE_W-1:0] VALUE_ONES = '1;
	localparam int CELL_TOP = (1 << ppa_pkg::CELL_W) - 1;
	localparam int NULL_IDX = int'(ppa_pkg::NULL_CELL);

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_we;
	logic [ppa_pkg::CELL_W-1:0] cfg_data;
	logic                       req_valid;
	logic                       req_ready;
	ppa_pkg::req_t              req;
	logic                       rsp_valid;
	logic                       rsp_ready;
	ppa_pkg::rsp_t              rsp;

	int                         mismatches;
	int                         outstanding;
	logic [ppa_pkg::CELL_W-1:0] fresh_mark;

	int burst_left;
	int pool_now;
	int stall_mode;
	int mode_left;

	int phase_pool [5] = '{1, 5, 64, ppa_pkg::PAIRS, 3};
	int phase_items [5] = '{70, 100, 130, 100, 50};

	pair_pool_allocator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	pool_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_data    (cfg_data),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.rsp         (rsp),
		.mismatches  (mismatches),
		.outstanding (outstanding),
		.fresh_mark  (fresh_mark)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// The receiver switches between always ready, coin-flip stalls and long stalls.
	initial begin
		rsp_ready = 1'b0;
		mode_left = 0;
		forever @(negedge clk) begin
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 2);
				mode_left = $urandom_range(8, 80);
			end
			mode_left--;
			case (stall_mode)
				0: rsp_ready <= 1'b1;
				1: rsp_ready <= 1'($urandom_range(0, 1));
				default: rsp_ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	initial begin
		#5_000_000;
		$display("[pair_pool_allocator] ERROR");
		$finish;
	end

	function automatic int usable_cells();
		return (pool_now > ppa_pkg::PAIRS) ? ppa_pkg::PAIRS : pool_now;
	endfunction

	// Called just after a falling edge; returns once the item has been accepted.
	task automatic offer(input ppa_pkg::req_t item);
		req <= item;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		burst_left--;
		if (burst_left <= 0) begin
			@(negedge clk) req_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 8);
		end
	endtask

	task automatic send_op(input logic [ppa_pkg::KIND_W-1:0] kind, input int cell_idx,
			input logic [ppa_pkg::VALUE_W-1:0] val, input int next);
		ppa_pkg::req_t item;
		item.kind = kind;
		item.cell_req = cell_idx[ppa_pkg::CELL_W-1:0];
		item.value = val;
		item.next_cell = next[ppa_pkg::CELL_W-1:0];
		@(negedge clk);
		offer(item);
	endtask

	function automatic logic [ppa_pkg::CELL_W-1:0] random_cell(input int lim, input int hw);
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 70 && hw > 0)
			return ppa_pkg::CELL_W'($urandom_range(0, hw - 1));
		else if (pick < 80)
			return ppa_pkg::NULL_CELL;
		else if (pick < 88 && lim > 0)
			return ppa_pkg::CELL_W'(lim - 1);
		return ppa_pkg::CELL_W'($urandom_range(0, CELL_TOP));
	endfunction

	// Reads stay below the high-water mark or outside the pool, so no
	// never-written cell is ever read back.
	function automatic logic [ppa_pkg::CELL_W-1:0] read_cell(input int lim, input int hw);
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 80 && hw > 0)
			return ppa_pkg::CELL_W'($urandom_range(0, hw - 1));
		else if (pick < 90)
			return ppa_pkg::NULL_CELL;
		return ppa_pkg::CELL_W'($urandom_range(lim, CELL_TOP));
	endfunction

	function automatic logic [ppa_pkg::VALUE_W-1:0] random_value();
		case ($urandom_range(0, 19))
			0: return VALUE_MAX;
			1: return VALUE_MIN;
			2: return '0;
			3: return VALUE_ONES;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic send_random();
		ppa_pkg::req_t item;
		int            lim;
		int            hw;
		int            pick;
		@(negedge clk);
		lim = usable_cells();
		hw = int'(fresh_mark);
		pick = $urandom_range(0, 99);
		item.cell_req = random_cell(lim, hw);
		item.value = random_value();
		item.next_cell = random_cell(lim, hw);
		if (pick < 35) begin
			item.kind = ppa_pkg::K_ALLOC;
		end else if (pick < 55) begin
			item.kind = ppa_pkg::K_READ;
			item.cell_req = read_cell(lim, hw);
		end else if (pick < 65) begin
			item.kind = ppa_pkg::K_SET_VALUE;
		end else if (pick < 75) begin
			item.kind = ppa_pkg::K_SET_LINK;
		end else if (pick < 95) begin
			item.kind = ppa_pkg::K_FREE;
		end else begin
			item.kind = ppa_pkg::KIND_W'($urandom_range(ppa_pkg::K_FREE + 1, KIND_TOP));
		end
		offer(item);
	endtask

	// The register is only written once every response is back.
	task automatic set_pool(input int cells);
		@(negedge clk) req_valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		cfg_data <= cells[ppa_pkg::CELL_W-1:0];
		cfg_we <= 1'b1;
		@(negedge clk) cfg_we <= 1'b0;
		pool_now = cells;
	endtask

	initial begin
		cfg_we = 1'b0;
		cfg_data = ppa_pkg::POOL_RESET;
		req_valid = 1'b0;
		req = '0;
		arst_n = 1'b0;
		pool_now = int'(ppa_pkg::POOL_RESET);
		burst_left = 1;
		repeat (5) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Full pool straight out of reset: value extremes, invalid cells and links,
		// a double free and the spare operation codes.
		send_op(ppa_pkg::K_ALLOC, 0, VALUE_MAX, NULL_IDX);
		send_op(ppa_pkg::K_ALLOC, 0, VALUE_MIN, 0);
		send_op(ppa_pkg::K_ALLOC, 0, '0, CELL_TOP);
		send_op(ppa_pkg::K_READ, 0, '0, 0);
		send_op(ppa_pkg::K_READ, 2, '0, 0);
		send_op(ppa_pkg::K_SET_VALUE, 1, VALUE_ONES, 0);
		send_op(ppa_pkg::K_SET_LINK, 2, '0, ppa_pkg::PAIRS - 1);
		send_op(ppa_pkg::K_READ, 1, '0, 0);
		send_op(ppa_pkg::K_READ, 2, '0, 0);
		send_op(ppa_pkg::K_READ, NULL_IDX, '0, 0);
		send_op(ppa_pkg::K_READ, CELL_TOP, '0, 0);
		send_op(ppa_pkg::K_SET_VALUE, NULL_IDX, VALUE_MAX, 0);
		send_op(ppa_pkg::K_SET_LINK, 1500, '0, 1);
		send_op(ppa_pkg::K_FREE, CELL_TOP, '0, 0);
		send_op(ppa_pkg::K_FREE, 0, '0, 0);
		send_op(ppa_pkg::K_FREE, 0, '0, 0);
		send_op(ppa_pkg::K_ALLOC, 0, 5, 1);
		send_op(ppa_pkg::K_ALLOC, 0, 6, 2);
		send_op(ppa_pkg::K_READ, 0, '0, 0);
		send_op(ppa_pkg::KIND_W'(ppa_pkg::K_FREE + 1), 0, VALUE_ONES, CELL_TOP);
		send_op(ppa_pkg::KIND_W'(KIND_TOP), CELL_TOP, VALUE_MIN, 0);
		send_op(ppa_pkg::K_FREE, 1, '0, 0);
		send_op(ppa_pkg::K_ALLOC, 0, VALUE_ONES, 1);
		repeat (100) send_random();

		// A two-cell pool runs dry.
		set_pool(2);
		send_op(ppa_pkg::K_ALLOC, 0, 11, 1);
		send_op(ppa_pkg::K_ALLOC, 0, 12, 0);
		send_op(ppa_pkg::K_ALLOC, 0, 13, 0);
		send_op(ppa_pkg::K_FREE, 1, '0, 0);
		send_op(ppa_pkg::K_ALLOC, 0, 14, NULL_IDX);
		send_op(ppa_pkg::K_READ, 2, '0, 0);
		repeat (50) send_random();

		// With no cells every allocate fails and every index is out of range.
		set_pool(0);
		send_op(ppa_pkg::K_ALLOC, 0, 15, 0);
		send_op(ppa_pkg::K_READ, 0, '0, 0);
		repeat (30) send_random();

		for (int p = 0; p < 5; p++) begin
			set_pool(phase_pool[p]);
			repeat (phase_items[p]) send_random();
		end

		@(negedge clk) req_valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("[pair_pool_allocator] OK");
		else
			$display("[pair_pool_allocator] ERROR");
		$finish;
	end

endmodule

// File: pair_pool_allocator.f
+incdir+sv
sv/ppa_pkg.sv
sv/ppa_ram.sv
sv/ppa_engine.sv
sv/pair_pool_allocator.sv
bench/pool_checker.sv
bench/testbench.sv
